// ===== design/grid_cell_area_fraction_macros.svh =====
// assertion macros shared by the checker of the grid cell area block
// depends on nothing; included by gcaf_checker.sv
`ifndef GRID_CELL_AREA_FRACTION_MACROS_SVH
`define GRID_CELL_AREA_FRACTION_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define GCAF_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define GCAF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/gcaf_pkg.sv =====
// types and constants of the grid cell area block
// no dependencies; imported by every module of the block
`default_nettype none

package gcaf_pkg;

    localparam int LEN_BITS   = 16;
    localparam int COMP_BITS  = 8;
    localparam int AREA_BITS  = 32;
    localparam int SUM_BITS   = 48;
    localparam int CNT_BITS   = 3;
    localparam int PRD_BITS   = 2 * LEN_BITS;
    localparam int IDX_BITS   = 2;
    localparam int CFG_BITS   = 16;
    localparam int S_DATA_BITS = 4 * COMP_BITS + 4 * LEN_BITS;
    localparam int M_RAW_BITS  = AREA_BITS + SUM_BITS + CNT_BITS;
    localparam int M_DATA_BITS = ((M_RAW_BITS + 7) / 8) * 8;

    typedef logic [LEN_BITS-1:0]  len_t;
    typedef logic [COMP_BITS-1:0] comp_t;
    typedef logic [AREA_BITS-1:0] area_t;
    typedef logic [SUM_BITS-1:0]  sum_t;
    typedef logic [PRD_BITS-1:0]  prd_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam len_t  WIDTH_RESET  = len_t'(256);
    localparam len_t  HEIGHT_RESET = len_t'(256);
    localparam comp_t TARGET_RESET = '0;
    localparam area_t AREA_MAX     = '1;
    localparam sum_t  SUM_MAX      = '1;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_TARGET = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_ONE_TRI,
        MODE_TWO_TRI,
        MODE_TRAP,
        MODE_FULL_CUT,
        MODE_FULL
    } area_mode_t;

    typedef struct packed {
        comp_t target;
        len_t  width;
        len_t  height;
    } cfg_t;

    typedef struct packed {
        comp_t comp_low_left;
        comp_t comp_high_left;
        comp_t comp_low_right;
        comp_t comp_high_right;
        len_t  bottom_cross;
        len_t  top_cross;
        len_t  left_cross;
        len_t  right_cross;
        logic  count_in_total;
        logic  last_cell;
    } cell_t;

    typedef struct packed {
        prd_t       p0;
        prd_t       p1;
        area_mode_t mode;
        cnt_t       corners;
        logic       count_in_total;
        logic       last_cell;
    } prod_stage_t;

endpackage

`default_nettype wire

// ===== design/gcaf_cfg_regs.sv =====
// configuration registers: target component and cell extents
// depends on gcaf_pkg
`default_nettype none

module gcaf_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [gcaf_pkg::IDX_BITS-1:0] cfg_index,
    input  wire logic [gcaf_pkg::CFG_BITS-1:0] cfg_data,
    output gcaf_pkg::cfg_t                     cfg
);
    import gcaf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET: cfg_reg.target <= cfg_data[COMP_BITS-1:0];
                CFG_WIDTH:  cfg_reg.width  <= cfg_data[LEN_BITS-1:0];
                CFG_HEIGHT: cfg_reg.height <= cfg_data[LEN_BITS-1:0];
                default:    ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/gcaf_product_unit.sv =====
// corner match, offset clamp, operand select and the two leg multipliers
// depends on gcaf_pkg
`default_nettype none

module gcaf_product_unit (
    input  wire gcaf_pkg::cell_t  item,
    input  wire gcaf_pkg::cfg_t   cfg,
    output gcaf_pkg::prod_stage_t prod
);
    import gcaf_pkg::*;

    len_t       w, h, b, t, l, r;
    len_t       wb, wt, hl_len, hr_len;
    logic       ll, hl, lr, hr;
    cnt_t       n;
    len_t       a0, b0, a1, b1;
    len_t       odd_a, odd_b;
    area_mode_t mode;

    always_comb begin
        w = cfg.width;
        h = cfg.height;
        b = (item.bottom_cross > w) ? w : item.bottom_cross;
        t = (item.top_cross    > w) ? w : item.top_cross;
        l = (item.left_cross   > h) ? h : item.left_cross;
        r = (item.right_cross  > h) ? h : item.right_cross;
        // legs measured from the far corner
        wb     = w - b;
        wt     = w - t;
        hl_len = h - l;
        hr_len = h - r;
    end

    assign ll = (item.comp_low_left   == cfg.target);
    assign hl = (item.comp_high_left  == cfg.target);
    assign lr = (item.comp_low_right  == cfg.target);
    assign hr = (item.comp_high_right == cfg.target);
    assign n  = cnt_t'(ll) + cnt_t'(hl) + cnt_t'(lr) + cnt_t'(hr);

    // triangle legs of the single odd corner (inside for one, outside for three)
    always_comb begin
        odd_a = wt;
        odd_b = hr_len;
        if (n == cnt_t'(1)) begin
            if (ll) begin
                odd_a = b;  odd_b = l;
            end else if (lr) begin
                odd_a = wb; odd_b = r;
            end else if (hl) begin
                odd_a = t;  odd_b = hl_len;
            end
        end else begin
            if (!ll) begin
                odd_a = b;  odd_b = l;
            end else if (!lr) begin
                odd_a = wb; odd_b = r;
            end else if (!hl) begin
                odd_a = t;  odd_b = hl_len;
            end
        end
    end

    always_comb begin
        a0   = '0;
        b0   = '0;
        a1   = '0;
        b1   = '0;
        mode = MODE_ZERO;
        case (n)
            cnt_t'(1): begin
                a0 = odd_a; b0 = odd_b;
                mode = MODE_ONE_TRI;
            end
            cnt_t'(2): begin
                if (ll && hr) begin
                    a0 = b;  b0 = l;  a1 = wt; b1 = hr_len;
                    mode = MODE_TWO_TRI;
                end else if (lr && hl) begin
                    a0 = wb; b0 = r;  a1 = t;  b1 = hl_len;
                    mode = MODE_TWO_TRI;
                end else if (ll && lr) begin
                    a0 = l;  b0 = w;  a1 = r;  b1 = w;
                    mode = MODE_TRAP;
                end else if (hl && hr) begin
                    a0 = hl_len; b0 = w; a1 = hr_len; b1 = w;
                    mode = MODE_TRAP;
                end else if (ll && hl) begin
                    a0 = b;  b0 = h;  a1 = t;  b1 = h;
                    mode = MODE_TRAP;
                end else begin
                    a0 = wb; b0 = h;  a1 = wt; b1 = h;
                    mode = MODE_TRAP;
                end
            end
            cnt_t'(3): begin
                a0 = w; b0 = h; a1 = odd_a; b1 = odd_b;
                mode = MODE_FULL_CUT;
            end
            cnt_t'(4): begin
                a0 = w; b0 = h;
                mode = MODE_FULL;
            end
            default: mode = MODE_ZERO;
        endcase
    end

    always_comb begin
        prod.p0             = prd_t'(a0) * prd_t'(b0);
        prod.p1             = prd_t'(a1) * prd_t'(b1);
        prod.mode           = mode;
        prod.corners        = n;
        prod.count_in_total = item.count_in_total;
        prod.last_cell      = item.last_cell;
    end

endmodule

`default_nettype wire

// ===== design/gcaf_area_accum.sv =====
// halving and combining of the products, area saturation, saturating total
// depends on gcaf_pkg
`default_nettype none

module gcaf_area_accum (
    input  wire gcaf_pkg::prod_stage_t prod,
    input  wire gcaf_pkg::sum_t        sum_cur,
    output gcaf_pkg::area_t            area,
    output gcaf_pkg::sum_t             sum_out,
    output gcaf_pkg::sum_t             sum_next
);
    import gcaf_pkg::*;

    logic [PRD_BITS:0] raw;
    logic [PRD_BITS:0] p0_ext, p1_ext;
    logic [SUM_BITS:0] acc;
    sum_t              acc_sat;

    assign p0_ext = {1'b0, prod.p0};
    assign p1_ext = {1'b0, prod.p1};

    always_comb begin
        case (prod.mode)
            MODE_ZERO:     raw = '0;
            MODE_ONE_TRI:  raw = p0_ext >> 1;
            MODE_TWO_TRI:  raw = (p0_ext >> 1) + (p1_ext >> 1);
            MODE_TRAP:     raw = (p0_ext + p1_ext) >> 1;
            MODE_FULL_CUT: raw = p0_ext - (p1_ext >> 1);
            MODE_FULL:     raw = p0_ext;
            default:       raw = '0;
        endcase
    end

    assign area = (raw > (PRD_BITS + 1)'(AREA_MAX)) ? AREA_MAX : raw[AREA_BITS-1:0];

    assign acc      = {1'b0, sum_cur} + (SUM_BITS + 1)'(area);
    assign acc_sat  = acc[SUM_BITS] ? SUM_MAX : acc[SUM_BITS-1:0];
    assign sum_out  = prod.count_in_total ? acc_sat : sum_cur;
    assign sum_next = prod.last_cell ? '0 : sum_out;

endmodule

`default_nettype wire

// ===== design/grid_cell_area_fraction.sv =====
// top level of the grid cell area block: stream ports and pipeline registers
// depends on gcaf_pkg, gcaf_cfg_regs, gcaf_product_unit, gcaf_area_accum
`default_nettype none

// Measures the area of one chosen component inside each rectangular grid cell
// of a marching-squares scan and keeps a saturating running total of the
// counted cells. One cell is taken per clock cycle while results are not
// stalled; each cell passes through the input register, the product
// register and the result register. The two leg multipliers between the input and
// product registers set the clock-to-clock path. Each stage holds its item
// only while the stage after it is full and stalled, so empty stages still
// fill while a result waits. Configuration writes are always accepted
// (cfg_ready is tied high) and take effect at once; write them only while
// no cell is in flight. The running total is cleared after the result of a
// cell that carries tlast.

module grid_cell_area_fraction (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input cell transactions
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // comp_low_left, comp_high_left, comp_low_right, comp_high_right,
    // bottom_cross, top_cross, left_cross, right_cross
    input  wire logic [gcaf_pkg::S_DATA_BITS-1:0] s_tdata,
    // count_in_total
    input  wire logic                             s_tuser,
    // last_cell
    input  wire logic                             s_tlast,
    // result transactions
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // cell_area, running_total, inside_corners, zero fill
    output logic [gcaf_pkg::M_DATA_BITS-1:0]      m_tdata,
    // total_final
    output logic                                  m_tlast,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gcaf_pkg::IDX_BITS-1:0]    cfg_index,
    input  wire logic [gcaf_pkg::CFG_BITS-1:0]    cfg_data
);
    import gcaf_pkg::*;

    cfg_t        cfg;
    cell_t       cell_in;
    cell_t       cell_reg;
    prod_stage_t prod_next;
    prod_stage_t prod_reg;
    area_t       area;
    sum_t        sum_out;
    sum_t        sum_next;
    sum_t        sum_reg;

    logic        in_valid_reg;
    logic        prod_valid_reg;
    logic        out_valid_reg;
    area_t       out_area_reg;
    sum_t        out_total_reg;
    cnt_t        out_corners_reg;
    logic        out_last_reg;

    logic        ready0, ready1, ready2;

    // register file, writes never stall
    assign cfg_ready = 1'b1;

    gcaf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // unpack the input transaction, first field in the lowest bits
    always_comb begin
        cell_in.comp_low_left   = s_tdata[0*COMP_BITS +: COMP_BITS];
        cell_in.comp_high_left  = s_tdata[1*COMP_BITS +: COMP_BITS];
        cell_in.comp_low_right  = s_tdata[2*COMP_BITS +: COMP_BITS];
        cell_in.comp_high_right = s_tdata[3*COMP_BITS +: COMP_BITS];
        cell_in.bottom_cross    = s_tdata[4*COMP_BITS + 0*LEN_BITS +: LEN_BITS];
        cell_in.top_cross       = s_tdata[4*COMP_BITS + 1*LEN_BITS +: LEN_BITS];
        cell_in.left_cross      = s_tdata[4*COMP_BITS + 2*LEN_BITS +: LEN_BITS];
        cell_in.right_cross     = s_tdata[4*COMP_BITS + 3*LEN_BITS +: LEN_BITS];
        cell_in.count_in_total  = s_tuser;
        cell_in.last_cell       = s_tlast;
    end

    // per-stage ready: a stage loads when empty or when its item moves on
    assign ready2   = !out_valid_reg || m_tready;
    assign ready1   = !prod_valid_reg || ready2;
    assign ready0   = !in_valid_reg || ready1;
    assign s_tready = ready0;

    // stage 1: corner match, clamping and the two multiplications
    gcaf_product_unit u_prod (
        .item (cell_reg),
        .cfg  (cfg),
        .prod (prod_next)
    );

    // stage 2: combine products and update the running total
    gcaf_area_accum u_accum (
        .prod     (prod_reg),
        .sum_cur  (sum_reg),
        .area     (area),
        .sum_out  (sum_out),
        .sum_next (sum_next)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_reg        <= '0;
        end else begin
            if (ready0) begin
                in_valid_reg <= s_tvalid;
            end
            if (ready1) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (ready2) begin
                out_valid_reg <= prod_valid_reg;
            end
            // total advances exactly once per cell, when it enters the result register
            if (ready2 && prod_valid_reg) begin
                sum_reg <= sum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ready0 && s_tvalid) begin
            cell_reg <= cell_in;
        end
        if (ready1 && in_valid_reg) begin
            prod_reg <= prod_next;
        end
        if (ready2 && prod_valid_reg) begin
            out_area_reg    <= area;
            out_total_reg   <= sum_out;
            out_corners_reg <= prod_reg.corners;
            out_last_reg    <= prod_reg.last_cell;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - M_RAW_BITS){1'b0}},
                       out_corners_reg, out_total_reg, out_area_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/gcaf_checker.sv =====
// port-level checker for the grid cell area block, bound to the top level
// depends on gcaf_pkg and grid_cell_area_fraction_macros.svh
`default_nettype none

`include "grid_cell_area_fraction_macros.svh"

module gcaf_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [gcaf_pkg::M_DATA_BITS-1:0] m_tdata,
    input  wire logic                             m_tlast
);
    import gcaf_pkg::*;

    sum_t m_total;

    assign m_total = m_tdata[AREA_BITS +: SUM_BITS];

    // a stalled result holds its payload
    `GCAF_ASSERT_CLK(a_out_hold, ((m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast))), "stalled result changed")

    // with nothing in the result register the block takes a new cell
    `GCAF_ASSERT_CLK(a_ready_when_out_empty, (!m_tvalid |-> s_tready), "input stalled with empty result register")

    // within a grid the total never falls from one result to the next
    `GCAF_ASSERT_CLK(a_total_grows, ((m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || (m_total >= $past(m_total)))), "running total decreased inside a grid")

    // reset empties the pipeline
    `GCAF_ASSERT_RST(a_reset_empty, (!aresetn |=> !m_tvalid), "result valid right after reset")

endmodule

bind grid_cell_area_fraction gcaf_checker u_gcaf_checker (.*);

`default_nettype wire

// ===== bench/grid_cell_area_fraction_tb.sv =====
// self-checking bench for grid_cell_area_fraction: cell stream in, area results out
// depends on gcaf_pkg and the grid_cell_area_fraction rtl; stands alone otherwise
`default_nettype none

module grid_cell_area_fraction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcaf_pkg::*;

    // no-transaction cycles before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet cycles after the last result, well past the three-stage pipeline
    localparam int END_WAIT       = 20;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES    = 120;
    // full maximum-size cells that push the running total high
    localparam int FULL_CELLS     = 8;
    // corner value that never equals the reset target
    localparam comp_t OTHER_COMP  = 8'hFF;

    typedef struct packed {
        area_t cell_area;
        sum_t  running_total;
        cnt_t  inside_corners;
        logic  total_final;
    } area_result_t;

    typedef struct {
        cell_t        item;
        bit           typed;
        area_result_t result;
    } table_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_BITS-1:0]    cfg_index = '0;
    logic [CFG_BITS-1:0]    cfg_data  = '0;

    // shadow copy of the block's registers and its running total
    comp_t grid_target   = TARGET_RESET;
    len_t  grid_width    = WIDTH_RESET;
    len_t  grid_height   = HEIGHT_RESET;
    sum_t  grid_area_sum = '0;

    // results still owed by the block, oldest first
    area_result_t pending_areas[$];
    table_row_t   cell_table[$];

    int fail_count   = 0;
    int stall_cycles = 0;
    int tx_idle_pct  = 38;
    int rx_idle_pct  = 72;
    bit rx_hold_req  = 1'b0;

    grid_cell_area_fraction dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock, rising edge at 4 ns
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // area predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] half_product(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 1;
    endfunction

    // area of the target component in one cell, then the running-total update
    function automatic area_result_t predict_cell_area(cell_t c);
        logic [63:0]  w, h, b, t, l, r;
        logic [63:0]  tri_ll, tri_lr, tri_hl, tri_hr, full, area, total;
        logic         in_ll, in_hl, in_lr, in_hr;
        cnt_t         n;
        area_result_t res;
        w = 64'(grid_width);
        h = 64'(grid_height);
        // crossings past the far edge are pulled back onto it
        b = (64'(c.bottom_cross) > w) ? w : 64'(c.bottom_cross);
        t = (64'(c.top_cross)    > w) ? w : 64'(c.top_cross);
        l = (64'(c.left_cross)   > h) ? h : 64'(c.left_cross);
        r = (64'(c.right_cross)  > h) ? h : 64'(c.right_cross);
        in_ll = (c.comp_low_left   == grid_target);
        in_hl = (c.comp_high_left  == grid_target);
        in_lr = (c.comp_low_right  == grid_target);
        in_hr = (c.comp_high_right == grid_target);
        // legs run from each triangle's own corner to the crossings
        tri_ll = half_product(b, l);
        tri_lr = half_product(w - b, r);
        tri_hl = half_product(t, h - l);
        tri_hr = half_product(w - t, h - r);
        full   = w * h;
        n = cnt_t'(in_ll) + cnt_t'(in_hl) + cnt_t'(in_lr) + cnt_t'(in_hr);
        case (n)
            3'd1: begin
                area = in_ll ? tri_ll : in_lr ? tri_lr : in_hl ? tri_hl : tri_hr;
            end
            3'd2: begin
                if (in_ll && in_hr)      area = tri_ll + tri_hr;
                else if (in_lr && in_hl) area = tri_lr + tri_hl;
                else if (in_ll && in_lr) area = (l * w + r * w) >> 1;
                else if (in_hl && in_hr) area = ((h - l) * w + (h - r) * w) >> 1;
                else if (in_ll && in_hl) area = (b * h + t * h) >> 1;
                else                     area = ((w - b) * h + (w - t) * h) >> 1;
            end
            3'd3: begin
                // full cell minus the triangle at the odd corner
                area = full - (!in_ll ? tri_ll : !in_lr ? tri_lr : !in_hl ? tri_hl : tri_hr);
            end
            3'd4: begin
                area = full;
            end
            default: begin
                area = '0;
            end
        endcase
        if (area > 64'(AREA_MAX)) area = 64'(AREA_MAX);
        if (c.count_in_total) begin
            total = 64'(grid_area_sum) + area;
            if (total > 64'(SUM_MAX)) total = 64'(SUM_MAX);
            grid_area_sum = sum_t'(total);
        end
        res.cell_area      = area_t'(area);
        res.running_total  = grid_area_sum;
        res.inside_corners = n;
        res.total_final    = c.last_cell;
        // the total restarts after the last cell of a grid
        if (c.last_cell) grid_area_sum = '0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // offset mix: edges, out-of-cell values, and mostly in-cell values
    function automatic len_t random_offset(len_t limit);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return len_t'($urandom);
            default: return len_t'($urandom_range(0, int'(limit)));
        endcase
    endfunction

    // random corner pattern around the current target, one in ten fully random
    function automatic cell_t random_cell();
        cell_t       c;
        logic [3:0]  pattern;
        comp_t       comps[4];
        bit          noise;
        pattern = 4'($urandom_range(0, 15));
        noise   = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < 4; k++) begin
            if (noise)           comps[k] = comp_t'($urandom);
            else if (pattern[k]) comps[k] = grid_target;
            else                 comps[k] = grid_target ^ comp_t'($urandom_range(1, 255));
        end
        c.comp_low_left   = comps[0];
        c.comp_high_left  = comps[1];
        c.comp_low_right  = comps[2];
        c.comp_high_right = comps[3];
        c.bottom_cross    = random_offset(grid_width);
        c.top_cross       = random_offset(grid_width);
        c.left_cross      = random_offset(grid_height);
        c.right_cross     = random_offset(grid_height);
        c.count_in_total  = ($urandom_range(0, 3) != 0);
        c.last_cell       = ($urandom_range(0, 24) == 0);
        return c;
    endfunction

    // offer one cell; the expectation is formed when the transaction is accepted
    task automatic send_cell(cell_t c, bit typed, area_result_t typed_res);
        area_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.right_cross, c.left_cross, c.top_cross, c.bottom_cross,
                     c.comp_high_right, c.comp_low_right, c.comp_high_left,
                     c.comp_low_left};
        s_tuser  <= c.count_in_total;
        s_tlast  <= c.last_cell;
        do @(posedge aclk); while (!s_tready);
        // predictor always runs so the shadow total stays in step
        predicted = predict_cell_area(c);
        pending_areas.push_back(typed ? typed_res : predicted);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TARGET: grid_target = value[COMP_BITS-1:0];
            CFG_WIDTH:  grid_width  = value;
            CFG_HEIGHT: grid_height = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // sender goes quiet until every owed result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_areas.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drain, pick the idling mix, then rewrite all three registers
    task automatic start_phase(comp_t target, len_t width, len_t height,
                               int tx_pct, int rx_pct);
        wait_for_results();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        // upper byte of a target write is junk the block must drop
        write_reg(CFG_TARGET, {8'($urandom), target});
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus an optional long hold-off
    // ------------------------------------------------------------------

    always @(negedge aclk) begin : result_sink
        int hold_left;
        if (rx_hold_req) begin
            hold_left   = HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        area_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cell_area      = m_tdata[0 +: AREA_BITS];
            got.running_total  = m_tdata[AREA_BITS +: SUM_BITS];
            got.inside_corners = m_tdata[AREA_BITS + SUM_BITS +: CNT_BITS];
            got.total_final    = m_tlast;
            if (pending_areas.size() == 0) begin
                $display("%0t ns: result with no cell pending, expected none, actual %h",
                         $time, got);
                fail_count++;
            end else begin
                want = pending_areas.pop_front();
                check_field("cell_area", 64'(want.cell_area), 64'(got.cell_area));
                check_field("running_total", 64'(want.running_total),
                            64'(got.running_total));
                check_field("inside_corners", 64'(want.inside_corners),
                            64'(got.inside_corners));
                check_field("total_final", 64'(want.total_final), 64'(got.total_final));
            end
        end
    end

    // watchdog: any accepted transaction on any channel restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no transaction for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        cell_t c;
        comp_t rand_target;

        // synchronous reset held, then released at a falling edge
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed cells at reset settings: target 0, 256 x 256 cell
        // typed rows: full cell, empty cell, clamped offsets, uncounted last cell, zero-offset corner
        cell_table.push_back('{cell_t'{8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                       1'b1, 1'b0},
                               1'b1, area_result_t'{32'd65536, 48'd65536, 3'd4, 1'b0}});
        cell_table.push_back('{cell_t'{OTHER_COMP, OTHER_COMP, OTHER_COMP, OTHER_COMP,
                                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0},
                               1'b1, area_result_t'{32'd0, 48'd65536, 3'd0, 1'b0}});
        // offsets far past the cell clamp to 256, so a 256 x 256 triangle
        cell_table.push_back('{cell_t'{8'd0, OTHER_COMP, OTHER_COMP, OTHER_COMP,
                                       16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b0},
                               1'b1, area_result_t'{32'd32768, 48'd98304, 3'd1, 1'b0}});
        // not counted: total shows the old sum, then clears after this last cell
        cell_table.push_back('{cell_t'{8'd0, 8'd0, 8'd0, 8'd0, 16'd5, 16'd6, 16'd7, 16'd8,
                                       1'b0, 1'b1},
                               1'b1, area_result_t'{32'd65536, 48'd98304, 3'd4, 1'b1}});
        // upper right corner with zero offsets: legs are the full cell sides
        cell_table.push_back('{cell_t'{OTHER_COMP, OTHER_COMP, OTHER_COMP, 8'd0,
                                       16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0},
                               1'b1, area_result_t'{32'd32768, 48'd32768, 3'd1, 1'b0}});
        // single corners
        cell_table.push_back('{cell_t'{OTHER_COMP, 8'd0, OTHER_COMP, OTHER_COMP,
                                       16'd3, 16'd100, 16'd40, 16'd9, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{OTHER_COMP, OTHER_COMP, 8'd0, OTHER_COMP,
                                       16'd30, 16'd11, 16'd12, 16'd200, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{8'd0, OTHER_COMP, OTHER_COMP, OTHER_COMP,
                                       16'd17, 16'd2, 16'd33, 16'd4, 1'b1, 1'b0}, 1'b0, '0});
        // diagonal pairs
        cell_table.push_back('{cell_t'{8'd0, OTHER_COMP, OTHER_COMP, 8'd0,
                                       16'd10, 16'd200, 16'd20, 16'd50, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{OTHER_COMP, 8'd0, 8'd0, OTHER_COMP,
                                       16'd100, 16'd60, 16'd120, 16'd80, 1'b1, 1'b0}, 1'b0, '0});
        // adjacent pairs: bottom, top, left, right trapezoids
        cell_table.push_back('{cell_t'{8'd0, OTHER_COMP, 8'd0, OTHER_COMP,
                                       16'd1, 16'd2, 16'd13, 16'd201, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{OTHER_COMP, 8'd0, OTHER_COMP, 8'd0,
                                       16'd1, 16'd2, 16'd77, 16'd5, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{8'd0, 8'd0, OTHER_COMP, OTHER_COMP,
                                       16'd3, 16'd255, 16'd9, 16'd9, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{OTHER_COMP, OTHER_COMP, 8'd0, 8'd0,
                                       16'd99, 16'd1, 16'd9, 16'd9, 1'b0, 1'b0}, 1'b0, '0});
        // three corners, each odd corner in turn
        cell_table.push_back('{cell_t'{OTHER_COMP, 8'd0, 8'd0, 8'd0,
                                       16'd50, 16'd7, 16'd60, 16'd8, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{8'd0, 8'd0, OTHER_COMP, 8'd0,
                                       16'd51, 16'd7, 16'd60, 16'd81, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{8'd0, OTHER_COMP, 8'd0, 8'd0,
                                       16'd5, 16'd71, 16'd63, 16'd8, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{8'd0, 8'd0, 8'd0, OTHER_COMP,
                                       16'd5, 16'd171, 16'd6, 16'd93, 1'b1, 1'b0}, 1'b0, '0});
        // mixed clamp and zero offsets, extreme corner values
        cell_table.push_back('{cell_t'{8'd0, OTHER_COMP, 8'd0, OTHER_COMP,
                                       16'h8000, 16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b0}, 1'b0, '0});
        cell_table.push_back('{cell_t'{8'd0, 8'd255, 8'd128, 8'd1,
                                       16'h8000, 16'h7FFF, 16'h0100, 16'h00FF, 1'b1, 1'b0},
                               1'b0, '0});
        cell_table.push_back('{cell_t'{OTHER_COMP, OTHER_COMP, 8'd0, 8'd0,
                                       16'd255, 16'd256, 16'd0, 16'd0, 1'b1, 1'b1}, 1'b0, '0});
        foreach (cell_table[i]) send_cell(cell_table[i].item, cell_table[i].typed,
                                          cell_table[i].result);

        // sender 38 / receiver 72 idle: largest target and cell
        start_phase(8'hFF, 16'hFFFF, 16'hFFFF, 38, 72);
        repeat (140) send_cell(random_cell(), 1'b0, '0);

        // smallest cell; receiver holds off so the pipeline backs up into the input
        start_phase(8'h00, 16'd1, 16'd1, 38, 72);
        rx_hold_req = 1'b1;
        repeat (140) send_cell(random_cell(), 1'b0, '0);

        // sender 72 / receiver 38 idle: random settings
        rand_target = comp_t'($urandom);
        start_phase(rand_target, len_t'($urandom_range(1, 65535)),
                    len_t'($urandom_range(1, 65535)), 72, 38);
        repeat (140) send_cell(random_cell(), 1'b0, '0);

        // zero width, then zero height
        start_phase(comp_t'($urandom), 16'd0, len_t'($urandom_range(1, 65535)), 72, 38);
        repeat (60) send_cell(random_cell(), 1'b0, '0);
        start_phase(comp_t'($urandom), 16'd300, 16'd0, 72, 38);
        repeat (60) send_cell(random_cell(), 1'b0, '0);

        // no idling: small cells, with a full drain halfway through
        start_phase(comp_t'($urandom), len_t'($urandom_range(1, 1000)),
                    len_t'($urandom_range(1, 1000)), 0, 0);
        repeat (70) send_cell(random_cell(), 1'b0, '0);
        wait_for_results();
        repeat (70) send_cell(random_cell(), 1'b0, '0);

        start_phase(8'd128, 16'd256, 16'hFFFF, 0, 0);
        repeat (140) send_cell(random_cell(), 1'b0, '0);

        // full maximum-size cells, the largest area one cell can give
        start_phase(comp_t'($urandom), 16'hFFFF, 16'hFFFF, 0, 0);
        repeat (FULL_CELLS) begin
            c = random_cell();
            c.comp_low_left   = grid_target;
            c.comp_high_left  = grid_target;
            c.comp_low_right  = grid_target;
            c.comp_high_right = grid_target;
            c.count_in_total  = 1'b1;
            c.last_cell       = 1'b0;
            send_cell(c, 1'b0, '0);
        end
        // a few more on the large total, then the last cell clears it
        repeat (12) begin
            c = random_cell();
            c.last_cell = 1'b0;
            send_cell(c, 1'b0, '0);
        end
        c = random_cell();
        c.last_cell = 1'b1;
        send_cell(c, 1'b0, '0);
        repeat (8) send_cell(random_cell(), 1'b0, '0);

        // drain, then watch a little longer for stray results
        wait_for_results();
        repeat (END_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
